FILE: rtl/sles_pkg.sv
// shared types, constants and helper functions of the serpentine led strip encoder
package sles_pkg;

  localparam int MAX_LEDS      = 1024;
  localparam int LED_COUNT_RST = 4;
  localparam int COL_LEN_RST   = 2;
  localparam int N_RST         = (LED_COUNT_RST > MAX_LEDS) ? MAX_LEDS : LED_COUNT_RST;
  localparam int ACTIVE_RST    = (N_RST / COL_LEN_RST) * COL_LEN_RST;

  localparam int CNT_W      = 11;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 16;
  localparam int CH_W       = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int DIV_STEPS  = CNT_W;
  localparam int DIV_CNT_W  = 4;
  localparam int FIFO_DEPTH = 4;

  localparam logic REG_LED_COUNT = 1'b0;
  localparam logic REG_COL_LEN   = 1'b1;

  localparam logic [CH_W-1:0] ENC_MARK = 8'h80;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] col_len;
    logic [CNT_W-1:0] active;
  } cfg_t;

  typedef struct packed {
    logic             frame_done;
    logic [CH_W-1:0]  blue_byte;
    logic [CH_W-1:0]  red_byte;
    logic [CH_W-1:0]  green_byte;
    logic [CNT_W-1:0] led_index;
  } res_t;

  typedef struct packed {
    logic w0_v;
    logic w1_v;
    res_t w0;
    res_t w1;
  } push_t;

  function automatic logic [CH_W-1:0] enc_byte(input logic [CH_W-1:0] c);
    enc_byte = (c >> 1) | ENC_MARK;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    eff_count = (32'(v) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : v;
  endfunction

endpackage

FILE: rtl/sles_cfg.sv
// configuration registers and serial remainder unit for the active pixel span
module sles_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sles_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sles_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sles_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output sles_pkg::cfg_t               cfg_o
);
  import sles_pkg::*;

  logic [CNT_W-1:0]     led_r, led_nxt;
  logic [CNT_W-1:0]     cl_r, cl_nxt;
  logic [CNT_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic                 wr;
  logic                 reg_sel;
  logic [CNT_W:0]       trial;
  logic [CNT_W-1:0]     rem_step;
  logic [CNT_W-1:0]     n_eff;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[2];
  assign n_eff      = eff_count(led_r);

  always_comb begin
    case (reg_sel)
      REG_LED_COUNT: cfg_prdata = CFG_DW'(led_r);
      REG_COL_LEN:   cfg_prdata = CFG_DW'(cl_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // one remainder bit per cycle, dividend msb first
  always_comb begin
    trial    = {rem_r, dvd_r[CNT_W-1]};
    rem_step = (trial >= {1'b0, cl_r}) ? CNT_W'(trial - {1'b0, cl_r}) : trial[CNT_W-1:0];
  end

  always_comb begin
    led_nxt     = led_r;
    cl_nxt      = cl_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    active_nxt  = active_r;
    if (wr) begin
      case (reg_sel)
        REG_LED_COUNT: led_nxt = cfg_pwdata[CNT_W-1:0];
        REG_COL_LEN:   cl_nxt  = cfg_pwdata[CNT_W-1:0];
        default:       led_nxt = led_r;
      endcase
      dvd_nxt     = eff_count(led_nxt);
      rem_nxt     = '0;
      div_cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      dvd_nxt     = dvd_r << 1;
      rem_nxt     = rem_step;
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
      if (div_cnt_r == DIV_CNT_W'(1)) begin
        active_nxt = (cl_r == '0) ? '0 : n_eff - rem_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r     <= CNT_W'(LED_COUNT_RST);
      cl_r      <= CNT_W'(COL_LEN_RST);
      div_cnt_r <= '0;
      active_r  <= CNT_W'(ACTIVE_RST);
    end else begin
      led_r     <= led_nxt;
      cl_r      <= cl_nxt;
      div_cnt_r <= div_cnt_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign cfg_o.busy    = (div_cnt_r != '0);
  assign cfg_o.n       = n_eff;
  assign cfg_o.col_len = cl_r;
  assign cfg_o.active  = active_r;

endmodule

FILE: rtl/sles_core.sv
// input register, frame state and serpentine remap of one pixel word
module sles_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sles_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  sles_pkg::cfg_t                 cfg_i,
  input  logic                           room2,
  output sles_pkg::push_t                push
);
  import sles_pkg::*;

  logic             s1_v_r;
  logic             s1_first_r;
  logic [LEN_W-1:0] s1_len_r;
  logic [CH_W-1:0]  s1_red_r, s1_green_r, s1_blue_r;

  logic             fa_r, fa_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;

  logic             go;
  logic             frame_ok;
  logic [LEN_W-1:0] n3;
  logic             fa;
  logic [POS_W-1:0] col, row;
  logic [CNT_W-1:0] pc;
  logic             emit_pix;
  logic             latch;
  logic [20:0]      prod;
  logic [CNT_W-1:0] offs;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] row1;
  res_t             pix_word, latch_word;

  assign go        = s1_v_r & room2;
  assign in_tready = !cfg_i.busy && (!s1_v_r || room2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_v_r <= 1'b1;
    end else if (go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_first_r <= in_tuser;
      s1_len_r   <= in_tdata[15:0];
      s1_red_r   <= in_tdata[23:16];
      s1_green_r <= in_tdata[31:24];
      s1_blue_r  <= in_tdata[39:32];
    end
  end

  assign n3       = {4'b0, cfg_i.n, 1'b0} + {5'b0, cfg_i.n};
  assign frame_ok = (cfg_i.n != '0) && (s1_len_r == n3);

  always_comb begin
    fa  = s1_first_r ? frame_ok : fa_r;
    col = s1_first_r ? '0 : col_r;
    row = s1_first_r ? '0 : row_r;
    pc  = s1_first_r ? '0 : pc_r;

    emit_pix = fa && (pc < cfg_i.active);
    prod     = col * cfg_i.col_len;
    offs     = col[0] ? (cfg_i.col_len - CNT_W'(1) - {1'b0, row}) : {1'b0, row};
    idx      = prod[CNT_W-1:0] + offs;
    row1     = {1'b0, row} + CNT_W'(1);

    col_nxt = col;
    row_nxt = row;
    if (emit_pix) begin
      if (row1 >= cfg_i.col_len) begin
        row_nxt = '0;
        col_nxt = col + POS_W'(1);
      end else begin
        row_nxt = row1[POS_W-1:0];
      end
    end
    pc_nxt = fa ? pc + CNT_W'(1) : pc;
    latch  = fa && (pc_nxt >= cfg_i.n);
    fa_nxt = fa && !latch;

    pix_word.led_index  = idx;
    pix_word.green_byte = enc_byte(s1_green_r);
    pix_word.red_byte   = enc_byte(s1_red_r);
    pix_word.blue_byte  = enc_byte(s1_blue_r);
    pix_word.frame_done = 1'b0;

    latch_word.led_index  = cfg_i.n;
    latch_word.green_byte = '0;
    latch_word.red_byte   = '0;
    latch_word.blue_byte  = '0;
    latch_word.frame_done = 1'b1;

    push.w0_v = go && (emit_pix || latch);
    push.w1_v = go && emit_pix && latch;
    push.w0   = emit_pix ? pix_word : latch_word;
    push.w1   = latch_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r  <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      pc_r  <= '0;
    end else if (go) begin
      fa_r  <= fa_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      pc_r  <= pc_nxt;
    end
  end

`ifndef SYNTH
  a_two_words_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.w1_v |-> (push.w0_v && !push.w0.frame_done && push.w1.frame_done))
    else $error("second word is not a latch after a pixel word");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.w0_v |-> room2)
    else $error("word pushed without queue room");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_i.busy |-> !in_tready)
    else $error("input taken while span is recomputed");
  a_latch_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (go && latch) |=> !fa_r)
    else $error("frame still open after latch word");
`endif

endmodule

FILE: rtl/sles_fifo.sv
// output word queue taking up to two words per cycle
module sles_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  sles_pkg::push_t push,
  output logic            room2,
  output logic            out_tvalid,
  input  logic            out_tready,
  output sles_pkg::res_t  out_word
);
  import sles_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic [PTR_W:0]   n_push;
  logic             pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  assign out_word   = mem[rd_ptr_r];
  assign n_push     = (PTR_W+1)'(push.w0_v) + (PTR_W+1)'(push.w1_v);
  assign room2      = (cnt_r - (PTR_W+1)'(pop)) <= (PTR_W+1)'(FIFO_DEPTH - 2);

  assign cnt_nxt    = cnt_r + n_push - (PTR_W+1)'(pop);
  assign wr_ptr_nxt = wr_ptr_r + n_push[PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);

  always_ff @(posedge clk) begin
    if (push.w0_v) begin
      mem[wr_ptr_r] <= push.w0;
    end
    if (push.w1_v) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

FILE: rtl/serpentine_led_strip_encoder.sv
// top level of the serpentine led strip encoder
//
// Pixels of a frame arrive on the in_ stream one word per cycle, panel order;
// in_tuser marks the first pixel, which also carries the frame byte length.
// A frame whose length is not three times the LED count gives no output.
// Each accepted pixel within a full column leaves on the out_ stream as a
// strip index with G,R,B bytes; the frame ends with a zero latch word that
// has out_tlast set and the LED count as index.
// Throughput: one pixel per cycle; a pixel that also closes the frame puts
// two words in the four-word output queue, so the output side sets the pace
// when frames are short. An accepted pixel passes the input register, then
// the output queue. When the receiver stalls the queue fills and in_tready
// drops once the input register holds a word and fewer than two queue
// entries are free. The cfg_ APB port holds led_count at 0x0 and
// column_length at 0x4; after each write a serial remainder unit recomputes
// the active pixel span, and in_tready is low while it runs.
// Reset clears the frame state and the queue and loads the register defaults.
module serpentine_led_strip_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sles_pkg::IN_DATA_W-1:0]  in_tdata,   // frame_bytes, red_in, green_in, blue_in
  input  logic                            in_tuser,   // first_pixel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sles_pkg::OUT_DATA_W-1:0] out_tdata,  // led_index, green, red, blue, pad
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sles_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [sles_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [sles_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import sles_pkg::*;

  cfg_t  cfg_s;
  push_t push_s;
  res_t  out_word;
  logic  room2;

  sles_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg_s)
  );

  sles_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_i     (cfg_s),
    .room2     (room2),
    .push      (push_s)
  );

  sles_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_s),
    .room2      (room2),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word)
  );

  assign out_tdata = {5'b0, out_word.blue_byte, out_word.red_byte,
                      out_word.green_byte, out_word.led_index};
  assign out_tlast = out_word.frame_done;

endmodule

FILE: bench/tb.sv
// self-checking bench for the serpentine led strip encoder: random frames checked word by word
module tb;
  import sles_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic             first;
    logic [LEN_W-1:0] frame_bytes;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } pixel_t;

  typedef struct {
    logic [CNT_W-1:0] led_index;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  blue;
    logic             frame_done;
  } led_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // frame_bytes, red_in, green_in, blue_in
  logic in_tuser = 1'b0;                 // first_pixel
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // led_index, green, red, blue, pad
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  pixel_t    pending_pixels[$];
  led_word_t strip_words[$];

  // shadow of the registers and frame state
  logic [CNT_W-1:0] led_count_r = CNT_W'(LED_COUNT_RST);
  logic [CNT_W-1:0] col_len_r = CNT_W'(COL_LEN_RST);
  logic             frame_live = 1'b0;
  logic [POS_W-1:0] col_cnt = '0;
  logic [POS_W-1:0] row_cnt = '0;
  logic [CNT_W-1:0] pix_cnt = '0;

  logic in_taken = 1'b0;
  int   pixels_taken = 0;
  int   mismatches = 0;
  int   stall_cycles = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  serpentine_led_strip_encoder dut (.*);

  always #5 clk = ~clk;

  function automatic logic [CH_W-1:0] led_byte(input logic [CH_W-1:0] c);
    return {1'b1, c[CH_W-1:1]};
  endfunction

  function automatic int strip_len();
    return (led_count_r > MAX_LEDS) ? MAX_LEDS : int'(led_count_r);
  endfunction

  task automatic report(input string field, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", field, exp_v, got_v, $time);
    mismatches++;
  endtask

  task automatic encode_pixel(input pixel_t p);
    int n;
    int cl;
    int active;
    int col;
    int row;
    int idx;
    led_word_t w;
    n = strip_len();
    cl = int'(col_len_r);
    active = (cl != 0) ? (n / cl) * cl : 0;
    if (p.first) begin
      frame_live = (n != 0) && (int'(p.frame_bytes) == 3 * n);
      pix_cnt = '0;
      col_cnt = '0;
      row_cnt = '0;
    end
    if (frame_live) begin
      if (int'(pix_cnt) < active) begin
        col = int'(col_cnt);
        row = int'(row_cnt);
        idx = col[0] ? col * cl + (cl - 1 - row) : col * cl + row;
        w.led_index = idx[CNT_W-1:0];
        w.green = led_byte(p.green);
        w.red = led_byte(p.red);
        w.blue = led_byte(p.blue);
        w.frame_done = 1'b0;
        strip_words.push_back(w);
        row++;
        if (row >= cl) begin
          row = 0;
          col++;
        end
        row_cnt = row[POS_W-1:0];
        col_cnt = col[POS_W-1:0];
      end
      pix_cnt = pix_cnt + 1'b1;
      if (int'(pix_cnt) >= n) begin
        w.led_index = n[CNT_W-1:0];
        w.green = '0;
        w.red = '0;
        w.blue = '0;
        w.frame_done = 1'b1;
        strip_words.push_back(w);
        frame_live = 1'b0;
      end
    end
  endtask

  // idle pattern: receiver-heavy, then sender-heavy, then none
  always_comb begin
    send_idle_pct = (pixels_taken < 430) ? 37 : (pixels_taken < 870) ? 77 : 0;
    recv_idle_pct = (pixels_taken < 430) ? 77 : (pixels_taken < 870) ? 37 : 0;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_pixels[0].first;
        in_tdata <= {pending_pixels[0].blue, pending_pixels[0].green,
                     pending_pixels[0].red, pending_pixels[0].frame_bytes};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      encode_pixel(pending_pixels.pop_front());
      pixels_taken <= pixels_taken + 1;
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    led_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (strip_words.size() == 0) begin
        report("unexpected word, led_index", -1, int'(out_tdata[CNT_W-1:0]));
      end else begin
        w = strip_words.pop_front();
        if (out_tdata[CNT_W-1:0] !== w.led_index)
          report("led_index", int'(w.led_index), int'(out_tdata[CNT_W-1:0]));
        if (out_tdata[CNT_W +: CH_W] !== w.green)
          report("green_byte", int'(w.green), int'(out_tdata[CNT_W +: CH_W]));
        if (out_tdata[CNT_W+CH_W +: CH_W] !== w.red)
          report("red_byte", int'(w.red), int'(out_tdata[CNT_W+CH_W +: CH_W]));
        if (out_tdata[CNT_W+2*CH_W +: CH_W] !== w.blue)
          report("blue_byte", int'(w.blue), int'(out_tdata[CNT_W+2*CH_W +: CH_W]));
        if (out_tlast !== w.frame_done)
          report("frame_done", int'(w.frame_done), int'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic settle();
    while (pending_pixels.size() != 0 || in_tvalid || strip_words.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {(CFG_DW-CNT_W)'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_LED_COUNT) led_count_r = value;
    else col_len_r = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_strip(input int leds, input int col_len);
    write_reg(REG_LED_COUNT, leds[CNT_W-1:0]);
    write_reg(REG_COL_LEN, col_len[CNT_W-1:0]);
  endtask

  task automatic push_pixel(input logic first, input int frame_bytes,
                            input int r, input int g, input int b);
    pixel_t p;
    p.first = first;
    p.frame_bytes = frame_bytes[LEN_W-1:0];
    p.red = r[CH_W-1:0];
    p.green = g[CH_W-1:0];
    p.blue = b[CH_W-1:0];
    pending_pixels.push_back(p);
  endtask

  task automatic push_random(input logic first, input int frame_bytes);
    push_pixel(first, frame_bytes, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
  endtask

  // frame of a given byte length: a first pixel followed by a given number of pixels
  task automatic push_frame(input int frame_bytes, input int body);
    push_random(1'b1, frame_bytes);
    repeat (body) push_random(1'b0, $urandom_range(0, 65535));
  endtask

  task automatic gen_phase(input int items);
    int n;
    int bad;
    int start;
    n = strip_len();
    start = pending_pixels.size() + pixels_taken;
    while (pending_pixels.size() + pixels_taken - start < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          push_frame(3 * n, (n > 0) ? n - 1 : 0);
        end
        6: begin
          bad = $urandom_range(0, 1) ? $urandom_range(0, 65535) : 3 * n + $urandom_range(0, 2) - 1;
          if (bad == 3 * n) bad = bad ^ 1;
          push_frame(bad, $urandom_range(0, n + 1));
        end
        7: begin
          push_frame(3 * n, (n > 1) ? $urandom_range(0, n - 2) : 0);
        end
        8: begin
          push_frame(3 * n, (n > 0 ? n - 1 : 0) + $urandom_range(1, 3));
        end
        default: begin
          repeat ($urandom_range(1, 3)) push_random(1'b0, $urandom_range(0, 65535));
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset strip: four leds in columns of two, twelve bytes per frame
    push_pixel(1'b1, 12, 8'h00, 8'h00, 8'h00);
    push_pixel(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(1'b0, 16'h5555, 8'h01, 8'hFE, 8'h80);
    push_pixel(1'b0, 16'hAAAA, 8'h7F, 8'h55, 8'hAA);
    push_pixel(1'b0, 0, 8'h12, 8'h34, 8'h56);
    push_pixel(1'b1, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    push_pixel(1'b0, 12, 8'h00, 8'hFF, 8'h00);
    push_pixel(1'b1, 12, 8'h81, 8'h42, 8'h24);
    push_pixel(1'b0, 0, 8'h18, 8'hE7, 8'h3C);
    push_frame(12, 3);
    push_pixel(1'b1, 13, 8'hC3, 8'h99, 8'h66);
    push_pixel(1'b1, 0, 8'h0F, 8'hF0, 8'h5A);
    push_pixel(1'b1, 11, 8'hA5, 8'h3C, 8'hC3);

    set_strip(5, 2);
    gen_phase(30);
    set_strip(1, 1);
    gen_phase(20);
    set_strip(0, 2);
    push_frame(0, 2);
    gen_phase(10);
    set_strip(7, 3);
    gen_phase(30);
    set_strip(6, 0);
    gen_phase(12);
    set_strip(3, 5);
    gen_phase(12);
    set_strip(16, 4);
    gen_phase(35);
    set_strip(2047, 1024);
    push_frame(3 * MAX_LEDS, MAX_LEDS - 1);
    push_random(1'b0, 0);
    set_strip(1024, 2047);
    push_frame(3 * MAX_LEDS, 4);
    push_frame(3 * MAX_LEDS + 1, 2);

    // frame left open across a change of the strip geometry
    set_strip(1024, 1);
    push_frame(3 * MAX_LEDS, 10);
    set_strip(3, 1);
    repeat (10) push_random(1'b0, $urandom_range(0, 65535));

    set_strip(12, 3);
    gen_phase(36);
    set_strip(2, 2);
    gen_phase(20);
    set_strip(9, 4);
    gen_phase(30);

    while (pending_pixels.size() != 0 || in_tvalid || strip_words.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
